// ===== rtl/pqd_pkg.sv =====
// shared types, widths and codes for the deduplicating priority queue
package pqd_pkg;

  // payload widths
  localparam int KEY_W  = 32;
  localparam int RANK_W = 16;
  localparam int STAT_W = 3;
  localparam int OCC_W  = 5;

  // default queue depth
  localparam int PQD_DEPTH = 16;

  // request modes
  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_QUEUED = 3'd0,
    STAT_DUP    = 3'd1,
    STAT_FULL   = 3'd2,
    STAT_POPPED = 3'd3,
    STAT_EMPTY  = 3'd4
  } pqd_status_t;

  // operation broadcast to every cell
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_CMP,
    OP_PUSH,
    OP_POP
  } pqd_op_t;

  // control sequencer states
  typedef enum logic {
    PQD_IDLE,
    PQD_APPLY
  } pqd_state_t;

  // broadcast command
  typedef struct packed {
    pqd_op_t            op;
    logic [KEY_W-1:0]   key;
    logic [RANK_W-1:0]  rank;
  } pqd_cmd_t;

  // one queue entry as seen by the neighbors
  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   key;
    logic [RANK_W-1:0]  rank;
  } pqd_entry_t;

  // chain summary toward the sequencer
  typedef struct packed {
    logic       dup;
    pqd_entry_t head;
  } pqd_sum_t;

endpackage

// ===== rtl/pqd_if.sv =====
// request and result channel interfaces
interface pqd_in_if import pqd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     mode;
  logic [KEY_W-1:0]         track_key;
  logic signed [RANK_W-1:0] rank;

  modport source (output valid, output mode, output track_key, output rank, input ready);
  modport sink (input valid, input mode, input track_key, input rank, output ready);
endinterface

interface pqd_out_if import pqd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic [KEY_W-1:0]         out_key;
  logic signed [RANK_W-1:0] out_rank;
  logic [OCC_W-1:0]         occupancy;

  modport source (output valid, output status, output out_key, output out_rank,
                  output occupancy, input ready);
  modport sink (input valid, input status, input out_key, input out_rank,
                input occupancy, output ready);
endinterface

// ===== rtl/priority_queue_with_dedup_core.sv =====
// top level: request sequencer, occupancy count and result register around the cell row
// timing: a request is accepted and its cells compare on that edge; the result register
//   loads in the apply step once it is free, which a waiting result can hold off
// one request at a time: the row compares, then shifts, before a new request is taken
// reset: synchronous active low; clears valid flags, count and result valid, not slot data
module priority_queue_with_dedup_core import pqd_pkg::*; #(
  parameter int QUEUE_DEPTH = PQD_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  pqd_in_if.sink    in_ch,
  pqd_out_if.source out_ch
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  pqd_state_t        state_r, state_nxt;
  logic              mode_r;
  logic [KEY_W-1:0]  key_r;
  logic [RANK_W-1:0] rank_r;
  logic [CW-1:0]     count_r, count_nxt;

  logic              out_valid_r;
  pqd_status_t       status_r, status_nxt;
  logic [KEY_W-1:0]  okey_r, okey_nxt;
  logic [RANK_W-1:0] orank_r, orank_nxt;
  logic [OCC_W-1:0]  occ_r;
  logic              load;

  pqd_cmd_t cmd;
  pqd_sum_t sum;

  pqd_chain #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_chain (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .sum   (sum)
  );

  // sequencer: compare on transfer, apply when the result register is free
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    status_nxt = status_r;
    okey_nxt   = '0;
    orank_nxt  = '0;
    load       = 1'b0;
    cmd.op     = OP_HOLD;
    cmd.key    = key_r;
    cmd.rank   = rank_r;
    case (state_r)
      PQD_IDLE: begin
        if (in_ch.valid) begin
          cmd.op    = OP_CMP;
          cmd.key   = in_ch.track_key;
          cmd.rank  = in_ch.rank;
          state_nxt = PQD_APPLY;
        end
      end
      PQD_APPLY: begin
        if (!out_valid_r || out_ch.ready) begin
          load      = 1'b1;
          state_nxt = PQD_IDLE;
          if (mode_r == MODE_POP) begin
            if (count_r == '0) begin
              status_nxt = STAT_EMPTY;
            end else begin
              status_nxt = STAT_POPPED;
              cmd.op     = OP_POP;
              okey_nxt   = sum.head.key;
              orank_nxt  = sum.head.rank;
              count_nxt  = count_r - 1'b1;
            end
          end else if (sum.dup) begin
            status_nxt = STAT_DUP;
          end else if (count_r == CW'(QUEUE_DEPTH)) begin
            status_nxt = STAT_FULL;
          end else begin
            status_nxt = STAT_QUEUED;
            cmd.op     = OP_PUSH;
            count_nxt  = count_r + 1'b1;
          end
        end
      end
      default: state_nxt = PQD_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= PQD_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      mode_r <= in_ch.mode;
      key_r  <= in_ch.track_key;
      rank_r <= in_ch.rank;
    end
    if (load) begin
      status_r <= status_nxt;
      okey_r   <= okey_nxt;
      orank_r  <= orank_nxt;
      occ_r    <= OCC_W'(count_nxt);
    end
  end

  assign in_ch.ready      = (state_r == PQD_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = status_r;
  assign out_ch.out_key   = okey_r;
  assign out_ch.out_rank  = orank_r;
  assign out_ch.occupancy = occ_r;

`ifndef SYNTHESIS
  // count never passes the queue depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("occupancy count above queue depth");

  // one request at a time: no transfer right after a transfer
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("request accepted during apply step");

  // a queued push grows the count by one
  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (load && status_nxt == STAT_QUEUED) |=> count_r == $past(count_r) + 1'b1)
    else $error("queued push did not grow count");

  // a pop is only reported with a valid head entry
  a_pop_head: assert property (@(posedge clk) disable iff (!rst_n)
    (load && status_nxt == STAT_POPPED) |-> (sum.head.valid && count_r != '0))
    else $error("pop reported without head entry");

  // result register is never overwritten while it still waits
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !load)
    else $error("result overwritten before transfer");
`endif

endmodule

// ===== rtl/pqd_cell.sv =====
// one queue slot: compares against the broadcast entry and shifts with its neighbors
module pqd_cell import pqd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  pqd_cmd_t   cmd,
  input  pqd_entry_t prev_ent,
  input  logic       prev_ins,
  input  pqd_entry_t next_ent,
  output pqd_entry_t ent,
  output logic       ins,
  output logic       match
);

  logic              valid_r, valid_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [RANK_W-1:0] rank_r, rank_nxt;
  logic              ins_r, ins_nxt;
  logic              match_r, match_nxt;

  // compare, insert or shift
  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    rank_nxt  = rank_r;
    ins_nxt   = ins_r;
    match_nxt = match_r;
    case (cmd.op)
      OP_CMP: begin
        match_nxt = valid_r && (key_r == cmd.key);
        ins_nxt   = !valid_r || ($signed(rank_r) < $signed(cmd.rank));
      end
      OP_PUSH: begin
        if (ins_r) begin
          if (prev_ins) begin
            valid_nxt = prev_ent.valid;
            key_nxt   = prev_ent.key;
            rank_nxt  = prev_ent.rank;
          end else begin
            valid_nxt = 1'b1;
            key_nxt   = cmd.key;
            rank_nxt  = cmd.rank;
          end
        end
      end
      OP_POP: begin
        valid_nxt = next_ent.valid;
        key_nxt   = next_ent.key;
        rank_nxt  = next_ent.rank;
      end
      default: ;
    endcase
  end

  // control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      ins_r   <= 1'b0;
      match_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      ins_r   <= ins_nxt;
      match_r <= match_nxt;
    end
  end

  // slot payload
  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    rank_r <= rank_nxt;
  end

  assign ent.valid = valid_r;
  assign ent.key   = key_r;
  assign ent.rank  = rank_r;
  assign ins       = ins_r;
  assign match     = match_r;

endmodule

// ===== rtl/pqd_chain.sv =====
// row of queue cells with neighbor links and duplicate summary
module pqd_chain import pqd_pkg::*; #(
  parameter int QUEUE_DEPTH = PQD_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  pqd_cmd_t cmd,
  output pqd_sum_t sum
);

  pqd_entry_t             ents [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] ins_v;
  logic [QUEUE_DEPTH-1:0] match_v;

  // cells, head at index zero
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    pqd_entry_t prev_ent, next_ent;
    logic       prev_ins;

    if (i == 0) begin : g_head
      assign prev_ent = '0;
      assign prev_ins = 1'b0;
    end else begin : g_mid
      assign prev_ent = ents[i-1];
      assign prev_ins = ins_v[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign next_ent = '0;
    end else begin : g_body
      assign next_ent = ents[i+1];
    end

    pqd_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .prev_ent (prev_ent),
      .prev_ins (prev_ins),
      .next_ent (next_ent),
      .ent      (ents[i]),
      .ins      (ins_v[i]),
      .match    (match_v[i])
    );
  end

  // registered per-cell matches reduce to one flag
  assign sum.dup  = |match_v;
  assign sum.head = ents[0];

endmodule
